// ===== src/fpdd_pkg.sv =====
`default_nettype none

package fpdd_pkg;

  // Field widths
  localparam int unsigned PressW = 17;
  localparam int unsigned AccelW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PhaseW = 2;

  // APB port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegIdxW = 3;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegDeployPressure  = 3'd0;
  localparam logic [RegIdxW-1:0] RegAccelCheckEn    = 3'd1;
  localparam logic [RegIdxW-1:0] RegAccelRiseThresh = 3'd2;
  localparam logic [RegIdxW-1:0] RegStandbyLockout  = 3'd3;
  localparam logic [RegIdxW-1:0] RegApogeeWindow    = 3'd4;
  localparam logic [RegIdxW-1:0] RegAscentLockout   = 3'd5;
  localparam logic [RegIdxW-1:0] RegStandbyStart    = 3'd6;

  // Flight phases
  localparam logic [PhaseW-1:0] PhStandby = 2'd0;
  localparam logic [PhaseW-1:0] PhAscent  = 2'd1;
  localparam logic [PhaseW-1:0] PhDescent = 2'd2;
  localparam logic [PhaseW-1:0] PhDeploy  = 2'd3;

  // Pressure rise over the minimum that marks apogee passed
  localparam logic [PressW:0] PressureMargin = 18'd100;

  // Reset values
  localparam logic [PressW-1:0] DeployPressureRst = '1;
  localparam logic [PressW-1:0] MinPressureRst    = '1;
  localparam logic [AccelW-1:0] MinAccelRst       = '1;

  typedef struct packed {
    logic [PressW-1:0] pressure;
    logic [AccelW-1:0] accel_magnitude;
    logic [TimeW-1:0]  sample_time;
  } sample_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              deploy_now;
    logic [PressW-1:0] lowest_pressure_out;
    logic [AccelW-1:0] lowest_accel_out;
    logic [AccelW-1:0] highest_accel_out;
    logic [PressW-1:0] pressure_at_deploy;
  } result_t;

  typedef struct packed {
    logic [PressW-1:0] deploy_pressure;
    logic              accel_check_enable;
    logic [AccelW-1:0] accel_rise_threshold;
    logic [TimeW-1:0]  launch_guard;
    logic [TimeW-1:0]  apex_dwell;
    logic [TimeW-1:0]  climb_guard;
    logic [TimeW-1:0]  standby_start;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/fpdd_regs.sv =====
`default_nettype none

module fpdd_regs
  import fpdd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic               wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[AddrW-1:2];

  // Register writes; unknown indexes drop the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deploy_pressure      <= DeployPressureRst;
      cfg.accel_check_enable   <= 1'b1;
      cfg.accel_rise_threshold <= '0;
      cfg.launch_guard         <= '0;
      cfg.apex_dwell           <= '0;
      cfg.climb_guard          <= '0;
      cfg.standby_start        <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegDeployPressure:  cfg.deploy_pressure      <= pwdata[PressW-1:0];
        RegAccelCheckEn:    cfg.accel_check_enable   <= pwdata[0];
        RegAccelRiseThresh: cfg.accel_rise_threshold <= pwdata[AccelW-1:0];
        RegStandbyLockout:  cfg.launch_guard         <= pwdata[TimeW-1:0];
        RegApogeeWindow:    cfg.apex_dwell           <= pwdata[TimeW-1:0];
        RegAscentLockout:   cfg.climb_guard          <= pwdata[TimeW-1:0];
        RegStandbyStart:    cfg.standby_start        <= pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      RegDeployPressure:  prdata = {{(DataW-PressW){1'b0}}, cfg.deploy_pressure};
      RegAccelCheckEn:    prdata = {{(DataW-1){1'b0}}, cfg.accel_check_enable};
      RegAccelRiseThresh: prdata = {{(DataW-AccelW){1'b0}}, cfg.accel_rise_threshold};
      RegStandbyLockout:  prdata = cfg.launch_guard;
      RegApogeeWindow:    prdata = cfg.apex_dwell;
      RegAscentLockout:   prdata = cfg.climb_guard;
      RegStandbyStart:    prdata = cfg.standby_start;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fpdd_track.sv =====
`default_nettype none

module fpdd_track
  import fpdd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  sample_t   smp,
  input  cfg_t      cfg,
  output result_t   res
);

  // Flight state
  logic [PhaseW-1:0] phase, phase_next;
  logic [PressW-1:0] min_press, min_press_next;
  logic [TimeW-1:0]  min_press_time, min_press_time_next;
  logic [AccelW-1:0] max_accel, max_accel_next;
  logic [AccelW-1:0] min_accel, min_accel_next;
  logic [TimeW-1:0]  ascent_time, ascent_time_next;
  logic [PressW-1:0] latched_press, latched_press_next;
  logic              deploy_now;

  logic [TimeW-1:0]  since_standby, since_min, since_ascent;
  logic [AccelW-1:0] accel_rise;
  logic [PressW:0]   press_limit;
  logic              standby_go, ascent_go;

  // Running extremes, current sample included
  always_comb begin
    if (smp.pressure < min_press) begin
      min_press_next      = smp.pressure;
      min_press_time_next = smp.sample_time;
    end else begin
      min_press_next      = min_press;
      min_press_time_next = min_press_time;
    end
    max_accel_next = (smp.accel_magnitude > max_accel) ? smp.accel_magnitude : max_accel;
    min_accel_next = (smp.accel_magnitude < min_accel) ? smp.accel_magnitude : min_accel;
  end

  // Transition tests; time differences wrap mod 2^32
  assign since_standby = smp.sample_time - cfg.standby_start;
  assign since_min     = smp.sample_time - min_press_time_next;
  assign since_ascent  = smp.sample_time - ascent_time;
  assign accel_rise    = smp.accel_magnitude - min_accel_next;
  assign press_limit   = {1'b0, min_press_next} + PressureMargin;

  assign standby_go = (since_standby > cfg.launch_guard)
                    && (!cfg.accel_check_enable || (accel_rise > cfg.accel_rise_threshold));
  assign ascent_go  = ({1'b0, smp.pressure} > press_limit)
                    && (since_min > cfg.apex_dwell)
                    && (since_ascent > cfg.climb_guard);

  // Phase sequencer
  always_comb begin
    phase_next         = phase;
    ascent_time_next   = ascent_time;
    latched_press_next = latched_press;
    deploy_now         = 1'b0;
    unique case (phase)
      PhStandby: begin
        if (standby_go) begin
          phase_next       = PhAscent;
          ascent_time_next = smp.sample_time;
        end
      end
      PhAscent: begin
        if (ascent_go) begin
          phase_next = PhDescent;
        end
      end
      PhDescent: begin
        if (smp.pressure >= cfg.deploy_pressure) begin
          phase_next         = PhDeploy;
          latched_press_next = smp.pressure;
          deploy_now         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PhStandby;
      min_press      <= MinPressureRst;
      min_press_time <= '0;
      max_accel      <= '0;
      min_accel      <= MinAccelRst;
      ascent_time    <= '0;
      latched_press  <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      min_press      <= min_press_next;
      min_press_time <= min_press_time_next;
      max_accel      <= max_accel_next;
      min_accel      <= min_accel_next;
      ascent_time    <= ascent_time_next;
      latched_press  <= latched_press_next;
    end
  end

  // Result beat built from the updated state
  always_comb begin
    res.phase               = phase_next;
    res.deploy_now          = deploy_now;
    res.lowest_pressure_out = min_press_next;
    res.lowest_accel_out    = min_accel_next;
    res.highest_accel_out   = max_accel_next;
    res.pressure_at_deploy  = latched_press_next;
  end

endmodule

`default_nettype wire

// ===== src/flight_phase_deploy_detector.sv =====
`default_nettype none
// A sample beat accepted into the input register moves on to the result register once that is free or draining.
// Throughput: one sample per cycle while result_stall does not hold the result register; the input
// register and the result register each hold one beat, and the state update runs between them.
// Reset (rst, synchronous, active high): both pipeline registers empty, standby phase,
// extremes and registers at their documented reset values.
module flight_phase_deploy_detector
  import fpdd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  sample_t smp;
  logic    smp_full;
  logic    advance, accept;
  result_t res;

  fpdd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: input beat moves on when the result register is free or draining
  assign advance      = smp_full & (~result_valid | ~result_stall);
  assign sample_stall = smp_full & ~advance;
  assign accept       = sample_valid & ~sample_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_full <= 1'b0;
    end else begin
      smp_full <= accept | (smp_full & ~advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample;
    end
  end

  fpdd_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .smp     (smp),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

// ===== src/fpdd_checker.sv =====
`default_nettype none

module fpdd_checker
  import fpdd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic result_valid,
  input wire logic result_stall,
  input result_t   result
);

  // Deploy pulse only comes with the deploy phase
  a_deploy_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.deploy_now |-> result.phase == PhDeploy)
    else $error("deploy_now without deploy phase");

  // Latched pressure stays zero until deploy
  a_latch_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.phase != PhDeploy |-> result.pressure_at_deploy == '0)
    else $error("pressure_at_deploy set before deploy");

  // Every beat has seen at least one sample, so min never exceeds max
  a_accel_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.lowest_accel_out <= result.highest_accel_out)
    else $error("accel minimum above maximum");

  // Stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

bind flight_phase_deploy_detector fpdd_checker u_fpdd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
